>>> src/pfts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic frame scheduler package
// Shared sizes, codes, table entry and result types of the frame scheduler.
// ----------------------------------------------------------------------------
package pfts_pkg;

	localparam int MAX_FRAMES    = 16;
	localparam int MAX_SENDERS   = 32;
	localparam int FRAME_AW      = $clog2(MAX_FRAMES);
	localparam int SENDER_AW     = $clog2(MAX_SENDERS);
	localparam int FCOUNT_W      = FRAME_AW + 1;
	localparam int RATE_W        = 10;
	localparam int MS_PER_SECOND = 1000;
	localparam int FREQ_MAX      = 1000;

	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_TICK       = 2'd2,
		OP_SEND       = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_FREQ     = 3'd1,
		ST_CONFLICT     = 3'd2,
		ST_FRAMES_FULL  = 3'd3,
		ST_SENDERS_FULL = 3'd4,
		ST_NOT_FOUND    = 3'd5,
		ST_EMPTY        = 3'd6,
		ST_NO_FILLER    = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_R_FIND,
		S_R_DIV,
		S_R_SLOT,
		S_U_FIND,
		S_U_REST,
		S_U_FFIND,
		S_U_SHIFT,
		S_T_FRAME,
		S_T_FILL,
		S_T_EMIT,
		S_E_FIND,
		S_E_FILL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [15:0]       id;
		logic [3:0]        dlc;
		logic [7:0]        flags;
		logic [RATE_W-1:0] rate;
		logic [RATE_W-1:0] interval;
		logic [RATE_W-1:0] ticks;
	} frame_t;

	typedef struct packed {
		logic        last;
		logic        transmit;
		logic [7:0]  flags;
		logic [3:0]  dlc;
		logic [15:0] frame_id;
		logic [4:0]  slot;
		status_t     status;
	} result_t;

	function automatic result_t make_res(status_t st, logic [4:0] slot, logic [15:0] id,
		logic [3:0] dlc, logic [7:0] fl, logic tx, logic lst);
		result_t r;
		r.status   = st;
		r.slot     = slot;
		r.frame_id = id;
		r.dlc      = dlc;
		r.flags    = fl;
		r.transmit = tx;
		r.last     = lst;
		return r;
	endfunction

endpackage

>>> src/pfts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval divider
// Restoring divider, one quotient bit per cycle, computing 1000 / frequency.
// ----------------------------------------------------------------------------
module pfts_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pfts_pkg::RATE_W-1:0]   divisor,
	output logic                          done,
	output logic [pfts_pkg::RATE_W-1:0]   quotient
);

	localparam int QW = pfts_pkg::RATE_W;
	localparam logic [QW-1:0] DIVIDEND = QW'(pfts_pkg::MS_PER_SECOND);

	logic [QW:0]         rem_q;
	logic [QW-1:0]       quo_q;
	logic [$clog2(QW)-1:0] cnt_q;
	logic                run_q;
	logic                done_q;
	logic [QW:0]         trial;

	assign trial    = {rem_q[QW-1:0], DIVIDEND[cnt_q]};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ($clog2(QW))'(QW - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial - {1'b0, divisor};
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

endmodule

>>> src/periodic_frame_tx_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic frame transmit scheduler
// Keeps a frame table and a sender slot table and walks them under a small
// sequencer to register, unregister, tick and send bus frames.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata / tuser / tlast
// s_axis    in   tdata: tx_id, rx_id, dlc, flags, frequency, has_fill; tuser: op
// m_axis    out  tdata: status, slot_index, frame_id, frame_dlc, frame_flags,
//                transmit; tlast: last
//
// Each beat is handled alone; the block is not ready until its work is done.
// Register takes up to 16 frame compares, a divider run and 32 slot checks.
// Unregister takes up to 32 + 32 sender checks plus 16 + 16 frame steps.
// A tick steps through each frame plus up to 32 sender checks per due frame,
// so the sender scan sets the worst case.
// Reset clears the frame count and the sender used bits at once; no sweep.
// A stalled result port holds the sequencer only when a new result is ready.
// ----------------------------------------------------------------------------
module periodic_frame_tx_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tx_id[15:0], rx_id[31:16], dlc[35:32], flags[43:36], frequency[59:44],
	// has_fill[60], zero pad [63:61]
	input  logic [63:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], slot_index[7:3], frame_id[23:8], frame_dlc[27:24],
	// frame_flags[35:28], transmit[36], zero pad [39:37]
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	localparam int FAW = pfts_pkg::FRAME_AW;
	localparam int SAW = pfts_pkg::SENDER_AW;
	localparam int FCW = pfts_pkg::FCOUNT_W;
	localparam int RW  = pfts_pkg::RATE_W;

	// Latched input beat.
	logic [15:0] in_tx_q, in_rx_q, in_freq_q;
	logic [3:0]  in_dlc_q;
	logic [7:0]  in_flags_q;
	logic        in_fill_q;

	pfts_pkg::state_t  state_q, state_d;
	logic [FCW-1:0]    fidx_q, fidx_d, count_q, count_d;
	logic [SAW-1:0]    sidx_q, sidx_d;
	pfts_pkg::result_t res_q, res_d, out_q;
	logic              pend_q, pend_d, out_valid_q;
	logic              push;

	pfts_pkg::frame_t frames_q [pfts_pkg::MAX_FRAMES];
	logic             used_q   [pfts_pkg::MAX_SENDERS];
	logic [15:0]      stx_q    [pfts_pkg::MAX_SENDERS];
	logic [15:0]      srx_q    [pfts_pkg::MAX_SENDERS];
	logic             sfill_q  [pfts_pkg::MAX_SENDERS];

	logic             fw_en, sw_set, sw_clr, div_start, div_done;
	logic [FAW-1:0]   fw_idx, rd_idx;
	pfts_pkg::frame_t fw_data, frd;
	logic [RW-1:0]    div_q;
	logic             accept, fscan_end, slast, su, fill_hit;
	logic [RW:0]      next_ticks;

	pfts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (in_freq_q[RW-1:0]),
		.done     (div_done),
		.quotient (div_q)
	);

	assign s_tready = (state_q == pfts_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {3'b000, out_q.transmit, out_q.flags, out_q.dlc, out_q.frame_id,
		out_q.slot, out_q.status};

	// One table read port; the shift step reads the entry above the one it writes.
	assign rd_idx     = (state_q == pfts_pkg::S_U_SHIFT) ? fidx_q[FAW-1:0] + 1'b1
		: fidx_q[FAW-1:0];
	assign frd        = frames_q[rd_idx];
	assign fscan_end  = (fidx_q >= count_q);
	assign slast      = (sidx_q == SAW'(pfts_pkg::MAX_SENDERS - 1));
	assign su         = used_q[sidx_q];
	assign fill_hit   = su && stx_q[sidx_q] == frd.id && sfill_q[sidx_q];
	assign next_ticks = {1'b0, frd.ticks} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfts_pkg::S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pfts_pkg::MAX_SENDERS; i++) begin
				used_q[i] <= 1'b0;
			end
		end else if (sw_set) begin
			used_q[sidx_q] <= 1'b1;
		end else if (sw_clr) begin
			used_q[sidx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		fidx_q <= fidx_d;
		sidx_q <= sidx_d;
		res_q  <= res_d;
		if (push) begin
			out_q <= res_q;
		end
		if (accept) begin
			in_tx_q    <= s_tdata[15:0];
			in_rx_q    <= s_tdata[31:16];
			in_dlc_q   <= s_tdata[35:32];
			in_flags_q <= s_tdata[43:36];
			in_freq_q  <= s_tdata[59:44];
			in_fill_q  <= s_tdata[60];
		end
		if (fw_en) begin
			frames_q[fw_idx] <= fw_data;
		end
		if (sw_set) begin
			stx_q[sidx_q]   <= in_tx_q;
			srx_q[sidx_q]   <= in_rx_q;
			sfill_q[sidx_q] <= in_fill_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		fidx_d    = fidx_q;
		sidx_d    = sidx_q;
		count_d   = count_q;
		res_d     = res_q;
		pend_d    = pend_q;
		push      = 1'b0;
		fw_en     = 1'b0;
		fw_idx    = fidx_q[FAW-1:0];
		fw_data   = frd;
		sw_set    = 1'b0;
		sw_clr    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			pfts_pkg::S_IDLE: begin
				fidx_d = '0;
				sidx_d = '0;
				if (accept) begin
					unique case (pfts_pkg::op_t'(s_tuser))
						pfts_pkg::OP_REGISTER: begin
							if (s_tdata[59:44] > 16'(pfts_pkg::FREQ_MAX)) begin
								res_d = pfts_pkg::make_res(pfts_pkg::ST_BAD_FREQ, '0, '0,
									'0, '0, 1'b0, 1'b1);
								state_d = pfts_pkg::S_RESP;
							end else begin
								state_d = pfts_pkg::S_R_FIND;
							end
						end
						pfts_pkg::OP_UNREGISTER: state_d = pfts_pkg::S_U_FIND;
						pfts_pkg::OP_TICK: begin
							pend_d  = 1'b0;
							state_d = pfts_pkg::S_T_FRAME;
						end
						pfts_pkg::OP_SEND: begin
							if (count_q == '0) begin
								res_d = pfts_pkg::make_res(pfts_pkg::ST_EMPTY, '0, '0,
									'0, '0, 1'b0, 1'b1);
								state_d = pfts_pkg::S_RESP;
							end else begin
								state_d = pfts_pkg::S_E_FIND;
							end
						end
						default: state_d = pfts_pkg::S_IDLE;
					endcase
				end
			end
			pfts_pkg::S_R_FIND: begin
				if (fscan_end) begin
					if (count_q >= FCW'(pfts_pkg::MAX_FRAMES)) begin
						res_d = pfts_pkg::make_res(pfts_pkg::ST_FRAMES_FULL, '0, '0,
							'0, '0, 1'b0, 1'b1);
						state_d = pfts_pkg::S_RESP;
					end else if (in_freq_q == '0) begin
						fw_en    = 1'b1;
						fw_idx   = count_q[FAW-1:0];
						fw_data  = '{id: in_tx_q, dlc: in_dlc_q, flags: in_flags_q,
							rate: '0, interval: '0, ticks: '0};
						count_d  = count_q + 1'b1;
						sidx_d   = '0;
						state_d  = pfts_pkg::S_R_SLOT;
					end else begin
						div_start = 1'b1;
						state_d   = pfts_pkg::S_R_DIV;
					end
				end else if (frd.id == in_tx_q) begin
					if ({{(16-RW){1'b0}}, frd.rate} != in_freq_q) begin
						res_d = pfts_pkg::make_res(pfts_pkg::ST_CONFLICT, '0, '0,
							'0, '0, 1'b0, 1'b1);
						state_d = pfts_pkg::S_RESP;
					end else begin
						sidx_d  = '0;
						state_d = pfts_pkg::S_R_SLOT;
					end
				end else begin
					fidx_d = fidx_q + 1'b1;
				end
			end
			pfts_pkg::S_R_DIV: begin
				if (div_done) begin
					fw_en   = 1'b1;
					fw_idx  = count_q[FAW-1:0];
					fw_data = '{id: in_tx_q, dlc: in_dlc_q, flags: in_flags_q,
						rate: in_freq_q[RW-1:0], interval: div_q, ticks: '0};
					count_d = count_q + 1'b1;
					sidx_d  = '0;
					state_d = pfts_pkg::S_R_SLOT;
				end
			end
			pfts_pkg::S_R_SLOT: begin
				if (!su) begin
					sw_set  = 1'b1;
					res_d   = pfts_pkg::make_res(pfts_pkg::ST_OK, 5'(sidx_q), '0,
						'0, '0, 1'b0, 1'b1);
					state_d = pfts_pkg::S_RESP;
				end else if (slast) begin
					res_d = pfts_pkg::make_res(pfts_pkg::ST_SENDERS_FULL, '0, '0,
						'0, '0, 1'b0, 1'b1);
					state_d = pfts_pkg::S_RESP;
				end else begin
					sidx_d = sidx_q + 1'b1;
				end
			end
			pfts_pkg::S_U_FIND: begin
				if (su && stx_q[sidx_q] == in_tx_q && srx_q[sidx_q] == in_rx_q) begin
					sw_clr  = 1'b1;
					sidx_d  = '0;
					state_d = pfts_pkg::S_U_REST;
				end else if (slast) begin
					res_d = pfts_pkg::make_res(pfts_pkg::ST_NOT_FOUND, '0, '0,
						'0, '0, 1'b0, 1'b1);
					state_d = pfts_pkg::S_RESP;
				end else begin
					sidx_d = sidx_q + 1'b1;
				end
			end
			pfts_pkg::S_U_REST: begin
				res_d = pfts_pkg::make_res(pfts_pkg::ST_OK, '0, '0, '0, '0, 1'b0, 1'b1);
				if (su && stx_q[sidx_q] == in_tx_q) begin
					state_d = pfts_pkg::S_RESP;
				end else if (slast) begin
					fidx_d  = '0;
					state_d = pfts_pkg::S_U_FFIND;
				end else begin
					sidx_d = sidx_q + 1'b1;
				end
			end
			pfts_pkg::S_U_FFIND: begin
				if (fscan_end) begin
					state_d = pfts_pkg::S_RESP;
				end else if (frd.id == in_tx_q) begin
					state_d = pfts_pkg::S_U_SHIFT;
				end else begin
					fidx_d = fidx_q + 1'b1;
				end
			end
			pfts_pkg::S_U_SHIFT: begin
				// Close the gap one entry per cycle, then drop the count.
				if ({1'b0, fidx_q} + 1'b1 < {1'b0, count_q}) begin
					fw_en  = 1'b1;
					fidx_d = fidx_q + 1'b1;
				end else begin
					count_d = count_q - 1'b1;
					state_d = pfts_pkg::S_RESP;
				end
			end
			pfts_pkg::S_T_FRAME: begin
				if (fscan_end) begin
					if (pend_q) begin
						res_d.last = 1'b1;
						pend_d     = 1'b0;
						state_d    = pfts_pkg::S_RESP;
					end else begin
						state_d = pfts_pkg::S_IDLE;
					end
				end else if (frd.rate == '0) begin
					fidx_d = fidx_q + 1'b1;
				end else if (next_ticks < {1'b0, frd.interval}) begin
					fw_en         = 1'b1;
					fw_data.ticks = next_ticks[RW-1:0];
					fidx_d        = fidx_q + 1'b1;
				end else begin
					fw_en         = 1'b1;
					fw_data.ticks = '0;
					sidx_d        = '0;
					state_d       = pfts_pkg::S_T_FILL;
				end
			end
			pfts_pkg::S_T_FILL: begin
				if (fill_hit) begin
					state_d = pfts_pkg::S_T_EMIT;
				end else if (slast) begin
					fidx_d  = fidx_q + 1'b1;
					state_d = pfts_pkg::S_T_FRAME;
				end else begin
					sidx_d = sidx_q + 1'b1;
				end
			end
			pfts_pkg::S_T_EMIT: begin
				// The previous due frame leaves once a later one is known to exist.
				if (!(pend_q && out_valid_q)) begin
					push    = pend_q;
					res_d   = pfts_pkg::make_res(pfts_pkg::ST_OK, '0, frd.id, frd.dlc,
						frd.flags, 1'b1, 1'b0);
					pend_d  = 1'b1;
					fidx_d  = fidx_q + 1'b1;
					state_d = pfts_pkg::S_T_FRAME;
				end
			end
			pfts_pkg::S_E_FIND: begin
				if (fscan_end) begin
					res_d = pfts_pkg::make_res(pfts_pkg::ST_NOT_FOUND, '0, '0,
						'0, '0, 1'b0, 1'b1);
					state_d = pfts_pkg::S_RESP;
				end else if (frd.id == in_tx_q) begin
					sidx_d  = '0;
					state_d = pfts_pkg::S_E_FILL;
				end else begin
					fidx_d = fidx_q + 1'b1;
				end
			end
			pfts_pkg::S_E_FILL: begin
				if (fill_hit) begin
					res_d = pfts_pkg::make_res(pfts_pkg::ST_OK, '0, frd.id, frd.dlc,
						frd.flags, 1'b1, 1'b1);
					state_d = pfts_pkg::S_RESP;
				end else if (slast) begin
					res_d = pfts_pkg::make_res(pfts_pkg::ST_NO_FILLER, '0, frd.id,
						frd.dlc, frd.flags, 1'b0, 1'b1);
					state_d = pfts_pkg::S_RESP;
				end else begin
					sidx_d = sidx_q + 1'b1;
				end
			end
			pfts_pkg::S_RESP: begin
				if (!out_valid_q) begin
					push    = 1'b1;
					state_d = pfts_pkg::S_IDLE;
				end
			end
			default: state_d = pfts_pkg::S_IDLE;
		endcase
	end

endmodule
